// ===== rtl/core/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared word types, round constants, initial hash and control structs.
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [0:7] chain_t;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] FILL_LAST  = 6'd63;  // last byte slot of a block
  localparam logic [5:0] LEN_START  = 6'd56;  // first byte of the length field
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST  = 3'd7;

  localparam chain_t IV_INIT = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Control from the sequencer to the message schedule.
  typedef struct packed {
    logic load;   // shift one byte into the block window
    logic step;   // advance the window by one expanded word
  } sched_ctrl_t;

  // Control from the sequencer to the round unit.
  typedef struct packed {
    logic init;   // copy chaining value into working variables
    logic step;   // run one compression round
    logic fold;   // add working variables into the chaining value
    logic clear;  // restore the initial hash
  } round_ctrl_t;

endpackage

// ===== rtl/core/sha_in_if.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message byte channel
// Valid/ready channel carrying one message byte with its flags.
// ----------------------------------------------------------------------------
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last_byte;

  modport source (output valid, data_byte, byte_valid, last_byte, input ready);
  modport sink   (input valid, data_byte, byte_valid, last_byte, output ready);
endinterface

// ===== rtl/core/sha_out_if.sv =====
// ----------------------------------------------------------------------------
// SHA-256 digest word channel
// Valid/ready channel carrying one digest word with its position.
// ----------------------------------------------------------------------------
interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== rtl/core/sha256_message_hasher.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Hashes a byte stream and returns the eight digest words per message.
// ----------------------------------------------------------------------------
// Throughput: one message byte per cycle while ready; the byte path is busy
//   for each full block's load, 64 rounds on the shared round unit, fold.
// After the last byte: padding bytes fill the block to its end, with an extra
//   padding block when the length spills, then one or two compressions, then
//   eight digest words, one per accepted cycle.
// Reset: asynchronous, active low; chaining value returns to the initial hash,
//   counters clear, and the block comes up ready for a message.
// ----------------------------------------------------------------------------
module sha256_message_hasher (
  input  logic clk_i,
  input  logic rst_ni,
  sha_in_if.sink    msg_i,
  sha_out_if.source dig_o
);
  import sha_pkg::*;

  // Sequencer states: gather bytes, pad, then compress and emit.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_INIT,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_e;

  state_e      state_q, state_d;
  logic [5:0]  fill_q, fill_d;     // bytes held in the current block
  logic [31:0] cnt_q, cnt_d;       // message length in bytes, wraps
  logic [5:0]  rnd_q, rnd_d;       // round number
  logic [2:0]  idx_q, idx_d;       // digest word on the output
  logic        pad_q, pad_d;       // message closed, padding in progress
  logic        mark_q, mark_d;     // 0x80 marker already placed
  logic        len_q, len_d;       // length field being written
  logic        final_q, final_d;   // current compression is the last one

  sched_ctrl_t sched_ctrl;
  round_ctrl_t round_ctrl;
  logic [7:0]  byte_val;
  logic [63:0] len_field;
  word_t       w_cur;
  chain_t      chain;

  // 64-bit big-endian length: upper word is count >> 29, lower count << 3.
  assign len_field = {29'd0, cnt_q, 3'd0};

  assign msg_i.ready       = (state_q == ST_IDLE);
  assign dig_o.valid       = (state_q == ST_OUT);
  assign dig_o.digest_word = chain[idx_q];
  assign dig_o.word_index  = idx_q;
  assign dig_o.last_word   = (idx_q == WORD_LAST);

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    cnt_d      = cnt_q;
    rnd_d      = rnd_q;
    idx_d      = idx_q;
    pad_d      = pad_q;
    mark_d     = mark_q;
    len_d      = len_q;
    final_d    = final_q;
    sched_ctrl = '0;
    round_ctrl = '0;
    byte_val   = msg_i.data_byte;

    case (state_q)
      ST_IDLE: begin
        if (msg_i.valid) begin
          if (msg_i.byte_valid) begin
            // append the byte; a full block goes straight to compression
            sched_ctrl.load = 1'b1;
            cnt_d  = cnt_q + 32'd1;
            fill_d = fill_q + 6'd1;
            if (fill_q == FILL_LAST) begin
              state_d = ST_INIT;
              pad_d   = msg_i.last_byte;
            end else if (msg_i.last_byte) begin
              state_d = ST_PAD;
              pad_d   = 1'b1;
            end
          end else if (msg_i.last_byte) begin
            state_d = ST_PAD;
            pad_d   = 1'b1;
          end
        end
      end

      ST_PAD: begin
        // feed one padding byte per cycle through the byte path
        sched_ctrl.load = 1'b1;
        fill_d = fill_q + 6'd1;
        if (!mark_q) begin
          byte_val = PAD_BYTE;
          mark_d   = 1'b1;
        end else if (len_q || (fill_q == LEN_START)) begin
          len_d    = 1'b1;
          byte_val = len_field[{~fill_q[2:0], 3'b000} +: 8];
        end else begin
          byte_val = 8'd0;
        end
        if (fill_q == FILL_LAST) begin
          state_d = ST_INIT;
          final_d = len_q;
        end
      end

      ST_INIT: begin
        round_ctrl.init = 1'b1;
        rnd_d   = '0;
        state_d = ST_ROUND;
      end

      ST_ROUND: begin
        round_ctrl.step = 1'b1;
        sched_ctrl.step = 1'b1;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == ROUND_LAST) begin
          state_d = ST_FOLD;
        end
      end

      ST_FOLD: begin
        round_ctrl.fold = 1'b1;
        if (final_q) begin
          state_d = ST_OUT;
          idx_d   = '0;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_OUT: begin
        if (dig_o.ready) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == WORD_LAST) begin
            // drop all message state for the next message
            round_ctrl.clear = 1'b1;
            state_d = ST_IDLE;
            fill_d  = '0;
            cnt_d   = '0;
            pad_d   = 1'b0;
            mark_d  = 1'b0;
            len_d   = 1'b0;
            final_d = 1'b0;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      cnt_q   <= '0;
      rnd_q   <= '0;
      idx_q   <= '0;
      pad_q   <= 1'b0;
      mark_q  <= 1'b0;
      len_q   <= 1'b0;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      pad_q   <= pad_d;
      mark_q  <= mark_d;
      len_q   <= len_d;
      final_q <= final_d;
    end
  end

  sha_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .byte_i (byte_val),
    .w_o    (w_cur)
  );

  sha_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (round_ctrl),
    .rnd_i   (rnd_q),
    .w_i     (w_cur),
    .chain_o (chain)
  );

  // Never take a byte while a digest word is on offer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(msg_i.ready && dig_o.valid))
    else $error("input ready while digest is pending");

  // Digest words follow in order without gaps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dig_o.valid && dig_o.ready && !dig_o.last_word) |=>
      (dig_o.valid && (dig_o.word_index == 3'($past(dig_o.word_index) + 3'd1))))
    else $error("digest word order broken");

  // After the last digest word the block is ready for a new message.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dig_o.valid && dig_o.ready && dig_o.last_word) |=> msg_i.ready)
    else $error("not ready after digest");

  // Closing a message always leaves the byte path busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (msg_i.valid && msg_i.ready && msg_i.last_byte) |=> !msg_i.ready)
    else $error("ready right after end of message");

  // A compression ends in the fold, never skips it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && rnd_q == ROUND_LAST) |=> (state_q == ST_FOLD))
    else $error("round count overrun");

endmodule

// ===== rtl/core/sha_sched.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message schedule
// Sixteen-word window: gathers block bytes, then expands one word per round.
// ----------------------------------------------------------------------------
module sha_sched (
  input  logic                 clk_i,
  input  sha_pkg::sched_ctrl_t ctrl_i,
  input  logic [7:0]           byte_i,
  output sha_pkg::word_t       w_o
);
  import sha_pkg::*;

  word_t win_q [16];
  word_t w1, w14, s0, s1, w_new;

  assign w1  = win_q[1];
  assign w14 = win_q[14];
  assign s0  = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
  assign s1  = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
  assign w_new = s1 + win_q[9] + s0 + win_q[0];
  assign w_o = win_q[0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      // shift the whole window left by one byte
      for (int k = 0; k < 15; k++) begin
        win_q[k] <= {win_q[k][23:0], win_q[k+1][31:24]};
      end
      win_q[15] <= {win_q[15][23:0], byte_i};
    end else if (ctrl_i.step) begin
      for (int k = 0; k < 15; k++) begin
        win_q[k] <= win_q[k+1];
      end
      win_q[15] <= w_new;
    end
  end

endmodule

// ===== rtl/core/sha_round.sv =====
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Working variables, one shared round datapath and the chaining value.
// ----------------------------------------------------------------------------
module sha_round (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sha_pkg::round_ctrl_t ctrl_i,
  input  logic [5:0]           rnd_i,
  input  sha_pkg::word_t       w_i,
  output sha_pkg::chain_t      chain_o
);
  import sha_pkg::*;

  word_t  v_q [8];
  chain_t chain_q;
  word_t  a, e, big_s0, big_s1, ch, maj, t1, t2;

  assign a      = v_q[0];
  assign e      = v_q[4];
  assign big_s1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
  assign big_s0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
  assign ch     = (e & v_q[5]) ^ (~e & v_q[6]);
  assign maj    = (a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1     = v_q[7] + big_s1 + ch + K_TAB[rnd_i] + w_i;
  assign t2     = big_s0 + maj;
  assign chain_o = chain_q;

  // Working variables carry no reset: always loaded before use.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.init) begin
      for (int k = 0; k < 8; k++) begin
        v_q[k] <= chain_q[k];
      end
    end else if (ctrl_i.step) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= e;
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= a;
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= IV_INIT;
    end else if (ctrl_i.clear) begin
      chain_q <= IV_INIT;
    end else if (ctrl_i.fold) begin
      for (int k = 0; k < 8; k++) begin
        chain_q[k] <= chain_q[k] + v_q[k];
      end
    end
  end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher testbench
// Drives byte words through the message channel and checks every digest word
// against a built-in SHA-256 predictor. The run opens with short directed
// messages: empty, single byte, "abc", a separate closing word and idle
// words. Random messages follow, mostly short, some on padding boundaries.
// Random stalls appear on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import sha_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int MAX_WAIT     = 18;
  localparam int RANDOM_BYTES = 350;
  localparam int DRAIN_CYCLES = 300;
  localparam int REPORT_LIMIT = 10;

  localparam logic [7:0] PAD_MARK = 8'h80;

  // Message lengths that land on the padding and block boundaries.
  localparam int EDGE_LEN [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // One byte word as sent; drain holds it back until every digest is out.
  typedef struct {
    logic [7:0] data;
    logic       bvalid;
    logic       last;
    bit         drain;
  } byte_item_t;

  typedef struct {
    word_t      word;
    logic [2:0] idx;
    logic       last;
  } digest_entry_t;

  logic clk_i;
  logic rst_ni;

  sha_in_if  msg ();
  sha_out_if dig ();

  sha256_message_hasher u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .msg_i  (msg),
    .dig_o  (dig)
  );

  byte_item_t    byte_q [$];     // byte words not yet offered
  digest_entry_t digest_q [$];   // digest words still owed by the block

  // Predictor state: chaining value, partial block and message length.
  word_t       chain_v [8];
  logic [7:0]  blk_buf [64];
  int          fill;
  logic [31:0] msg_bytes;

  byte_item_t    cur_item;
  digest_entry_t got_word;
  int            send_gap, recv_gap;
  bit            send_burst, recv_burst;
  int            errors;
  int            cycle_cnt;

  function automatic word_t rotr(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_message();
    for (int k = 0; k < 8; k++) chain_v[k] = HASH_INIT[k];
    fill      = 0;
    msg_bytes = '0;
  endfunction

  // Run the 64 rounds over blk_buf and fold the result into chain_v.
  function automatic void compress_block();
    word_t w [16];
    word_t v [8];
    word_t t1, t2, s0, s1, a, e;
    for (int k = 0; k < 16; k++)
      w[k] = {blk_buf[4*k], blk_buf[4*k+1], blk_buf[4*k+2], blk_buf[4*k+3]};
    for (int k = 0; k < 8; k++) v[k] = chain_v[k];
    for (int r = 0; r < 64; r++) begin
      if (r >= 16) begin
        s0 = rotr(w[(r-15) & 15], 7) ^ rotr(w[(r-15) & 15], 18) ^ (w[(r-15) & 15] >> 3);
        s1 = rotr(w[(r-2) & 15], 17) ^ rotr(w[(r-2) & 15], 19) ^ (w[(r-2) & 15] >> 10);
        w[r & 15] = s1 + w[(r-7) & 15] + s0 + w[r & 15];
      end
      a  = v[0];
      e  = v[4];
      t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
           + ROUND_K[r] + w[r & 15];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = e;
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = a;
      v[0] = t1 + t2;
    end
    for (int k = 0; k < 8; k++) chain_v[k] += v[k];
  endfunction

  // Absorb one accepted byte word; on the closing word pad, compress and
  // queue the eight digest words the block owes.
  function automatic void hash_byte_item(byte_item_t it);
    digest_entry_t out_word;
    if (it.bvalid) begin
      blk_buf[fill] = it.data;
      fill++;
      msg_bytes++;
      if (fill == 64) begin
        compress_block();
        fill = 0;
      end
    end
    if (!it.last) return;
    blk_buf[fill] = PAD_MARK;
    for (int k = fill + 1; k < 64; k++) blk_buf[k] = '0;
    // No room for the length field: spill it into an extra block.
    if (fill >= 56) begin
      compress_block();
      for (int k = 0; k < 64; k++) blk_buf[k] = '0;
    end
    {blk_buf[56], blk_buf[57], blk_buf[58], blk_buf[59]} = msg_bytes >> 29;
    {blk_buf[60], blk_buf[61], blk_buf[62], blk_buf[63]} = msg_bytes << 3;
    compress_block();
    for (int k = 0; k < 8; k++) begin
      out_word.word = chain_v[k];
      out_word.idx  = 3'(k);
      out_word.last = (k == 7);
      digest_q.push_back(out_word);
    end
    restart_message();
  endfunction

  function automatic void queue_item(logic [7:0] d, logic bv, logic l, bit dr);
    byte_item_t it;
    it.data   = d;
    it.bvalid = bv;
    it.last   = l;
    it.drain  = dr;
    byte_q.push_back(it);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Byte driver: wait out the drawn gap, offer the next word, hold it until
  // accepted. Predict at the accepting edge so expectations follow order.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg.valid      <= 1'b0;
      msg.data_byte  <= '0;
      msg.byte_valid <= 1'b0;
      msg.last_byte  <= 1'b0;
      send_gap   = 0;
      send_burst = 1'b0;
      restart_message();
    end else begin
      if (msg.valid && msg.ready) begin
        hash_byte_item(cur_item);
        // Toggle now and then between back-to-back and gapped traffic.
        if ($urandom_range(0, 23) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (!msg.valid || msg.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          msg.valid <= 1'b0;
        end else if (byte_q.size() > 0 && (!byte_q[0].drain || digest_q.size() == 0)) begin
          cur_item = byte_q.pop_front();
          msg.valid      <= 1'b1;
          msg.data_byte  <= cur_item.data;
          msg.byte_valid <= cur_item.bvalid;
          msg.last_byte  <= cur_item.last;
        end else begin
          msg.valid <= 1'b0;
        end
      end
    end
  end

  // Digest monitor: check each accepted word against the oldest expectation,
  // then drop ready for a drawn number of cycles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dig.ready <= 1'b0;
      recv_gap   = 0;
      recv_burst = 1'b0;
    end else begin
      if (dig.valid && dig.ready) begin
        if (digest_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("unexpected digest word %h index %0d last %b",
                     dig.digest_word, dig.word_index, dig.last_word);
        end else begin
          got_word = digest_q.pop_front();
          if (dig.digest_word !== got_word.word || dig.word_index !== got_word.idx ||
              dig.last_word !== got_word.last) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display("digest mismatch: expected %h index %0d last %b, got %h index %0d last %b",
                       got_word.word, got_word.idx, got_word.last,
                       dig.digest_word, dig.word_index, dig.last_word);
          end
        end
        if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
        recv_gap = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        dig.ready <= 1'b0;
      end else begin
        dig.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    int len;
    int n_bytes;
    bit close_apart;
    bit drain_now;

    rst_ni = 1'b0;

    // Directed: idle word, empty message, "abc" closed on its last byte.
    queue_item(8'hff, 1'b0, 1'b0, 1'b0);
    queue_item(8'h5a, 1'b0, 1'b1, 1'b0);
    queue_item(8'h61, 1'b1, 1'b0, 1'b0);
    queue_item(8'h62, 1'b1, 1'b0, 1'b0);
    queue_item(8'h63, 1'b1, 1'b1, 1'b0);
    // Hold off until both digests are out, then bytes 00 and ff with an
    // idle word in between and a separate closing word.
    queue_item(8'h00, 1'b1, 1'b0, 1'b1);
    queue_item(8'h00, 1'b0, 1'b0, 1'b0);
    queue_item(8'hff, 1'b1, 1'b0, 1'b0);
    queue_item(8'h00, 1'b0, 1'b1, 1'b0);
    // Single byte equal to the pad marker.
    queue_item(PAD_MARK, 1'b1, 1'b1, 1'b0);

    // Random messages: mostly short, a quarter on the boundary lengths,
    // with stray idle words and now and then a full drain first.
    n_bytes = 0;
    while (n_bytes < RANDOM_BYTES) begin
      if ($urandom_range(0, 3) == 0) len = EDGE_LEN[$urandom_range(0, 8)];
      else len = $urandom_range(0, 40);
      close_apart = (len == 0) || ($urandom_range(0, 1) == 1);
      drain_now   = ($urandom_range(0, 11) == 0);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
          n_bytes++;
        end
        queue_item(8'($urandom_range(0, 255)), 1'b1, !close_apart && (i == len - 1),
                   drain_now && (i == 0));
      end
      if (close_apart)
        queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, drain_now && (len == 0));
      n_bytes += len + int'(close_apart);
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Wait for every word to be sent and every digest to return.
    while (byte_q.size() != 0 || msg.valid || digest_q.size() != 0) @(posedge clk_i);
    // Give any stray output a chance to show up.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule
